// ===== design/skl_pkg.sv =====
// Shared types and constants for the streaming keyword lexer.
// Holds the scan mode enum, token kind codes and the result word layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skl_pkg;

    // Default saturation limit for the running token length.
    localparam int MAX_TOKEN_LEN_DEF = 255;

    // Result queue depth; an item may push two results at once.
    localparam int QUEUE_DEPTH = 4;

    // Field widths of the streaming ports.
    localparam int KIND_W = 5;
    localparam int LEN_W  = 8;

    // Scanner modes.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_ID,
        MODE_ID_F5,
        MODE_ID_LNG,
        MODE_INT,
        MODE_FLT,
        MODE_EQ,
        MODE_BANG,
        MODE_PIPE,
        MODE_AMP,
        MODE_ERR
    } scan_mode_t;

    // Token kind codes.
    localparam logic [KIND_W-1:0] K_IDENT  = 5'd0;
    localparam logic [KIND_W-1:0] K_TFLOAT = 5'd1;
    localparam logic [KIND_W-1:0] K_TINT   = 5'd2;
    localparam logic [KIND_W-1:0] K_IF     = 5'd3;
    localparam logic [KIND_W-1:0] K_GOTO   = 5'd4;
    localparam logic [KIND_W-1:0] K_ASSIGN = 5'd5;
    localparam logic [KIND_W-1:0] K_EQ     = 5'd6;
    localparam logic [KIND_W-1:0] K_NE     = 5'd7;
    localparam logic [KIND_W-1:0] K_OR     = 5'd8;
    localparam logic [KIND_W-1:0] K_AND    = 5'd9;
    localparam logic [KIND_W-1:0] K_ADD    = 5'd10;
    localparam logic [KIND_W-1:0] K_MINUS  = 5'd11;
    localparam logic [KIND_W-1:0] K_MULT   = 5'd12;
    localparam logic [KIND_W-1:0] K_DIV    = 5'd13;
    localparam logic [KIND_W-1:0] K_ILIT   = 5'd14;
    localparam logic [KIND_W-1:0] K_FLIT   = 5'd15;
    localparam logic [KIND_W-1:0] K_SEMI   = 5'd16;
    localparam logic [KIND_W-1:0] K_POPEN  = 5'd17;
    localparam logic [KIND_W-1:0] K_PCLOSE = 5'd18;
    localparam logic [KIND_W-1:0] K_COPEN  = 5'd19;
    localparam logic [KIND_W-1:0] K_CCLOSE = 5'd20;
    localparam logic [KIND_W-1:0] K_ERROR  = 5'd21;
    localparam logic [KIND_W-1:0] K_END    = 5'd22;

    // Keyword spellings packed with the first character in the low byte.
    localparam logic [31:0] KW_IF   = 32'h0000_6669;
    localparam logic [31:0] KW_INT  = 32'h0074_6E69;
    localparam logic [31:0] KW_GOTO = 32'h6F74_6F67;
    localparam logic [31:0] KW_FLOA = 32'h616F_6C66;

    // One result word.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic              last;
    } result_t;

    // Up to two results produced by one step.
    typedef struct packed {
        logic    v0;
        result_t r0;
        logic    v1;
        result_t r1;
    } step_out_t;

endpackage

`default_nettype wire

// ===== design/skl_scan_core.sv =====
// Scanner state and combinational step logic of the keyword lexer.
// Produces up to two results per step; uses skl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skl_scan_core #(
    parameter int MAX_TOKEN_LEN = skl_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              cmd,
    input  wire logic [7:0]        char_code,
    output skl_pkg::step_out_t     step_out
);
    import skl_pkg::*;

    localparam int RL_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int OW   = (RL_W > LEN_W) ? RL_W : LEN_W;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    scan_mode_t         mode_reg, mode_next;
    logic [RL_W-1:0]    run_len_reg, run_len_next;
    logic [31:0]        head_reg, head_next;

    // Decode results.
    logic               c_alpha, c_digit, c_dot;
    logic               id_class, extend, pair_hit;
    logic [KIND_W-1:0]  pair_kind;
    logic               close_valid, close_err;
    logic [KIND_W-1:0]  close_kind;
    logic [LEN_W-1:0]   close_len;
    logic               fi_emit;
    logic [KIND_W-1:0]  fi_kind;
    scan_mode_t         fi_mode;
    logic [LEN_W-1:0]   run_len_sat;
    logic [OW-1:0]      run_len_wide;
    logic [KIND_W-1:0]  ident_kind;

    // Output length saturates at the port maximum.
    always_comb begin
        run_len_wide = OW'(run_len_reg);
        run_len_sat  = (run_len_wide > OW'(255)) ? 8'hFF : run_len_wide[LEN_W-1:0];
    end

    // Character classes, keyword match and closing of an open token.
    always_comb begin
        c_alpha  = is_alpha(char_code);
        c_digit  = is_digit(char_code);
        c_dot    = (char_code == ".");
        id_class = (mode_reg == MODE_ID) || (mode_reg == MODE_ID_F5) ||
                   (mode_reg == MODE_ID_LNG);
        extend   = (id_class && c_alpha) ||
                   (((mode_reg == MODE_INT) || (mode_reg == MODE_FLT)) && c_digit) ||
                   ((mode_reg == MODE_INT) && c_dot);

        pair_hit  = 1'b0;
        pair_kind = K_EQ;
        unique case (mode_reg)
            MODE_EQ:   begin pair_hit = (char_code == "="); pair_kind = K_EQ;  end
            MODE_BANG: begin pair_hit = (char_code == "="); pair_kind = K_NE;  end
            MODE_PIPE: begin pair_hit = (char_code == "|"); pair_kind = K_OR;  end
            MODE_AMP:  begin pair_hit = (char_code == "&"); pair_kind = K_AND; end
            default:   ;
        endcase

        // Keywords if, int and goto need the exact spelling held in the short-identifier mode; float has its own mode.
        ident_kind = K_IDENT;
        if (mode_reg == MODE_ID_F5) begin
            ident_kind = K_TFLOAT;
        end else if (mode_reg == MODE_ID) begin
            if (run_len_reg == RL_W'(2) && head_reg == KW_IF) begin
                ident_kind = K_IF;
            end else if (run_len_reg == RL_W'(3) && head_reg == KW_INT) begin
                ident_kind = K_TINT;
            end else if (run_len_reg == RL_W'(4) && head_reg == KW_GOTO) begin
                ident_kind = K_GOTO;
            end
        end

        close_valid = 1'b1;
        close_err   = 1'b0;
        close_kind  = K_IDENT;
        close_len   = run_len_sat;
        unique case (mode_reg)
            MODE_ID, MODE_ID_F5, MODE_ID_LNG: close_kind = ident_kind;
            MODE_INT: close_kind = K_ILIT;
            MODE_FLT: close_kind = K_FLIT;
            MODE_EQ: begin
                close_kind = K_ASSIGN;
                close_len  = 8'd1;
            end
            MODE_BANG, MODE_PIPE, MODE_AMP: begin
                close_kind = K_ERROR;
                close_len  = 8'd1;
                close_err  = 1'b1;
            end
            default: close_valid = 1'b0;
        endcase
    end

    // What a character does when no token is open.
    always_comb begin
        fi_emit = 1'b1;
        fi_kind = K_ERROR;
        fi_mode = MODE_IDLE;
        if (is_space(char_code)) begin
            fi_emit = 1'b0;
        end else if (c_alpha) begin
            fi_emit = 1'b0;
            fi_mode = MODE_ID;
        end else if (c_digit) begin
            fi_emit = 1'b0;
            fi_mode = MODE_INT;
        end else begin
            unique case (char_code)
                "=": begin fi_emit = 1'b0; fi_mode = MODE_EQ;   end
                "!": begin fi_emit = 1'b0; fi_mode = MODE_BANG; end
                "|": begin fi_emit = 1'b0; fi_mode = MODE_PIPE; end
                "&": begin fi_emit = 1'b0; fi_mode = MODE_AMP;  end
                "+": fi_kind = K_ADD;
                "-": fi_kind = K_MINUS;
                "*": fi_kind = K_MULT;
                "/": fi_kind = K_DIV;
                ";": fi_kind = K_SEMI;
                "(": fi_kind = K_POPEN;
                ")": fi_kind = K_PCLOSE;
                "{": fi_kind = K_COPEN;
                "}": fi_kind = K_CCLOSE;
                default: begin
                    fi_kind = K_ERROR;
                    fi_mode = MODE_ERR;
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        mode_next    = mode_reg;
        run_len_next = run_len_reg;
        head_next    = head_reg;
        if (cmd) begin
            mode_next    = MODE_IDLE;
            run_len_next = '0;
            head_next    = '0;
        end else if (mode_reg == MODE_ERR) begin
            mode_next = MODE_ERR;
        end else if (extend) begin
            if (mode_reg == MODE_ID && run_len_reg == RL_W'(4)) begin
                mode_next = (head_reg == KW_FLOA && char_code == "t") ?
                            MODE_ID_F5 : MODE_ID_LNG;
            end else if (mode_reg == MODE_ID_F5) begin
                mode_next = MODE_ID_LNG;
            end else if (mode_reg == MODE_INT && c_dot) begin
                mode_next = MODE_FLT;
            end
            if (run_len_reg < RL_W'(4)) begin
                head_next = head_reg | (32'(char_code) << {run_len_reg[1:0], 3'b000});
            end
            if (run_len_reg < RL_W'(MAX_TOKEN_LEN)) begin
                run_len_next = run_len_reg + RL_W'(1);
            end
        end else if (pair_hit) begin
            mode_next    = MODE_IDLE;
            run_len_next = '0;
            head_next    = '0;
        end else if (close_err) begin
            mode_next    = MODE_ERR;
            run_len_next = '0;
            head_next    = '0;
        end else begin
            mode_next = fi_mode;
            if (c_alpha || c_digit) begin
                run_len_next = RL_W'(1);
                head_next    = 32'(char_code);
            end else begin
                run_len_next = '0;
                head_next    = '0;
            end
        end
    end

    // Results of this step.
    always_comb begin
        step_out         = '0;
        step_out.r0.kind = K_END;
        step_out.r1.kind = K_END;
        if (cmd) begin
            if (mode_reg != MODE_ERR && close_valid) begin
                step_out.v0      = 1'b1;
                step_out.r0.kind = close_kind;
                step_out.r0.len  = close_len;
                step_out.v1      = 1'b1;
            end else begin
                step_out.v0 = 1'b1;
            end
        end else if (mode_reg == MODE_ERR || extend) begin
            step_out.v0 = 1'b0;
        end else if (pair_hit) begin
            step_out.v0      = 1'b1;
            step_out.r0.kind = pair_kind;
            step_out.r0.len  = 8'd2;
        end else if (close_valid) begin
            step_out.v0      = 1'b1;
            step_out.r0.kind = close_kind;
            step_out.r0.len  = close_len;
            if (!close_err && fi_emit) begin
                step_out.v1      = 1'b1;
                step_out.r1.kind = fi_kind;
                step_out.r1.len  = 8'd1;
            end
        end else if (fi_emit) begin
            step_out.v0      = 1'b1;
            step_out.r0.kind = fi_kind;
            step_out.r0.len  = 8'd1;
        end
        step_out.r0.last = !step_out.v1;
        step_out.r1.last = 1'b1;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            run_len_reg <= '0;
            head_reg    <= '0;
        end else if (step) begin
            mode_reg    <= mode_next;
            run_len_reg <= run_len_next;
            head_reg    <= head_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/skl_result_queue.sv =====
// Small result queue of the keyword lexer that takes up to two words per cycle.
// Drives the master stream side; uses skl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skl_result_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire skl_pkg::step_out_t push_data,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output skl_pkg::result_t        out_data
);
    import skl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [CNT_W-1:0]   push_n;

    // Room for a full two-word step.
    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill count updates.
    always_comb begin
        push_n      = push ? (CNT_W'(push_data.v0) + CNT_W'(push_data.v1)) : '0;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage; the second word of a step goes to the following slot.
    always_ff @(posedge aclk) begin
        if (push && push_data.v0) begin
            entry_reg[wr_ptr_reg] <= push_data.r0;
        end
        if (push && push_data.v1) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data.r1;
        end
    end

endmodule

`default_nettype wire

// ===== design/streaming_keyword_lexer.sv =====
// Top level of the streaming keyword lexer: input register, scanner, result queue.
// Depends on skl_pkg, skl_scan_core and skl_result_queue.
//
//  Channel | Dir | tdata                            | tuser    | tlast
//  s_      | in  | [7:0] char_code                  | [0] cmd  | -
//  m_      | out | [4:0] token_kind, [12:5] length  | -        | last_of_run
//
// A character is taken into the input register and scanned once the queue has
// room for a full step; its results are registered into the queue, from which
// they leave in order on the master side.
// One word is accepted per cycle while the queue has room; a word that closes
// one token and emits another gives two results for the single-word master port.
// Reset clears the scan state and empties the queue; stalls on the master side
// back up through the queue to s_tready.
`timescale 1ns / 1ps
`default_nettype none

module streaming_keyword_lexer #(
    parameter int MAX_TOKEN_LEN = skl_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] char_code
    input  wire logic [0:0]  s_tuser,    // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [4:0] token_kind, [12:5] token_length
    output logic             m_tlast
);
    import skl_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic        cmd_reg;
    logic [7:0]  char_reg;
    logic        advance;
    logic        room;
    logic        s_accept;
    step_out_t   step_out;
    result_t     out_word;

    // Input register: refills in the same cycle that it hands over.
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tuser[0];
            char_reg <= s_tdata;
        end
    end

    // Scanner step.
    skl_scan_core #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .cmd       (cmd_reg),
        .char_code (char_reg),
        .step_out  (step_out)
    );

    // Result queue toward the master side.
    skl_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_data (step_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {3'b000, out_word.len, out_word.kind};
    assign m_tlast = out_word.last;

endmodule

`default_nettype wire
